/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge.
`define WSOD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define WSOD_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define WSOD_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wsod_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsod_pkg
// Shared types and constants of the window sigma outlier detector.
// ----------------------------------------------------------------------------
package wsod_pkg;

  localparam int WIN_W       = 7;   // window_size register width
  localparam int SF_W        = 12;  // sigma_factor register width, Q4.8
  localparam int BOUND_W     = 16;  // threshold register width
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int SIGMA_SHIFT = 16;  // square of the Q4.8 scale

  typedef enum logic [STATUS_W-1:0] {
    ST_NOMINAL      = 3'd0,
    ST_BELOW        = 3'd1,
    ST_ABOVE        = 3'd2,
    ST_INSUFFICIENT = 3'd3,
    ST_INVALID      = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_USE_UPPER = 3'd1,
    REG_USE_LOWER = 3'd2,
    REG_UPPER     = 3'd3,
    REG_LOWER     = 3'd4,
    REG_WINDOW    = 3'd5,
    REG_SIGMA     = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MULB,
    S_MULC,
    S_FINAL
  } state_e;

  typedef struct packed {
    logic               mode;
    logic               use_upper;
    logic               use_lower;
    logic [BOUND_W-1:0] upper;
    logic [BOUND_W-1:0] lower;
    logic [WIN_W-1:0]   window_size;
    logic [SF_W-1:0]    sigma_factor;
  } cfg_t;

  typedef struct packed {
    logic               sigma;
    status_e            status;
    logic [COUNT_W-1:0] number;
  } job_t;

endpackage

/* rtl/wsod_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsod_if
// Valid/ready channels of the detector: samples, results and config writes.
// ----------------------------------------------------------------------------
interface wsod_in_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface wsod_out_if;
  logic                             valid;
  logic                             ready;
  logic [wsod_pkg::STATUS_W-1:0]    status;
  logic [wsod_pkg::COUNT_W-1:0]     sample_number;
  modport source (output valid, output status, output sample_number, input ready);
  modport sink (input valid, input status, input sample_number, output ready);
endinterface

interface wsod_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wsod_pkg::CFG_IDX_W-1:0]  index;
  logic [wsod_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/wsod_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsod_front
// Accepts samples, counts them and settles every status that needs no window.
// ----------------------------------------------------------------------------
module wsod_front #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wsod_in_if.sink           in_i,
  input  wsod_pkg::cfg_t    cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output wsod_pkg::job_t    job_o
);

  localparam int SB = SAMPLE_BITS;

  logic [wsod_pkg::COUNT_W-1:0] seen_q, seen_d;
  logic signed [SB-1:0]         x;
  logic signed [SB-1:0]         ub;
  logic signed [SB-1:0]         lb;
  logic                         ws_bad;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  assign x  = $signed(in_i.sample);
  assign ub = $signed(SB'(cfg_i.upper));
  assign lb = $signed(SB'(cfg_i.lower));
  assign ws_bad = (int'(cfg_i.window_size) < 2) || (int'(cfg_i.window_size) > WINDOW_MAX);

  // saturate at all ones
  assign seen_d = (&seen_q) ? seen_q : seen_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (push_o) begin
      seen_q <= seen_d;
    end
  end

  always_comb begin
    job_o.sigma  = 1'b0;
    job_o.status = wsod_pkg::ST_NOMINAL;
    job_o.number = seen_d;
    if (!cfg_i.mode) begin
      if (!cfg_i.use_upper && !cfg_i.use_lower) begin
        job_o.status = wsod_pkg::ST_INVALID;
      end else if (cfg_i.use_upper && (x > ub)) begin
        job_o.status = wsod_pkg::ST_ABOVE;
      end else if (cfg_i.use_lower && (x < lb)) begin
        job_o.status = wsod_pkg::ST_BELOW;
      end
    end else if (ws_bad || (cfg_i.sigma_factor == '0)) begin
      job_o.status = wsod_pkg::ST_INVALID;
    end else begin
      job_o.sigma = 1'b1;
    end
  end

endmodule

/* rtl/wsod_queue.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// wsod_queue
// Short first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
module wsod_queue #(
  parameter int W = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  localparam int DEPTH = wsod_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [W-1:0]    slot_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] count_q;

  assign full_o  = (count_q == CNTW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  `WSOD_IMPLIES(a_no_overflow, push_i, count_q != CNTW'(DEPTH), "queue push while full")
  `WSOD_IMPLIES(a_no_underflow, pop_i, count_q != '0, "queue pop while empty")
  `WSOD_NEXT(a_count_hold, push_i && pop_i, $stable(count_q), "count moved on push with pop")

endmodule

/* rtl/wsod_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// wsod_back
// Window store, running sums and the four-step sigma test sequencer.
// ----------------------------------------------------------------------------
module wsod_back #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wsod_pkg::cfg_t         cfg_i,
  input  logic                   clear_i,
  input  logic                   q_valid_i,
  input  wsod_pkg::job_t         q_job_i,
  input  logic [SAMPLE_BITS-1:0] q_sample_i,
  output logic                   q_pop_o,
  wsod_out_if.source             out_o
);

  localparam int SB  = SAMPLE_BITS;
  localparam int L   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int NW  = wsod_pkg::WIN_W;
  localparam int SFW = wsod_pkg::SF_W;
  localparam int SW  = SB + L + 1;
  localparam int QW  = 2 * SB + L - 1;
  localparam int DW  = SB + L + 2;
  localparam int AW  = DW - 1;
  localparam int VW  = QW + NW;
  localparam int EW  = (VW > 2 * AW) ? VW : 2 * AW;
  localparam int KW  = 2 * SFW + NW;
  localparam int VL  = (VW + 1) / 2;
  localparam int VH  = VW - VL;
  localparam int HW  = 2 * AW + NW;
  localparam int LW  = HW + wsod_pkg::SIGMA_SHIFT;
  localparam int RW  = KW + VW;
  localparam int CW  = (LW > RW) ? LW : RW;
  localparam int XW  = 2 * SB - 1;
  localparam int IW  = ((L > NW) ? L : NW) + 1;

  wsod_pkg::state_e state_q, state_d;

  // window state
  logic [SB-1:0]        win_mem [WINDOW_MAX];
  logic [SB-1:0]        rd_q;
  logic [L-1:0]         slot_q, slot_d;
  logic [NW-1:0]        fill_q, fill_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic [QW-1:0]        sq_q, sq_d;

  // pipeline of the sigma test
  logic signed [SB-1:0]         x_q;
  logic [wsod_pkg::COUNT_W-1:0] number_q;
  logic                         d_neg_q;
  logic [AW-1:0]                dmag_q;
  logic [VW-1:0]                nq_q;
  logic [2*AW-1:0]              s2_q;
  logic [2*SFW-1:0]             k2_q;
  logic [2*AW-1:0]              dsq_q;
  logic [VW-1:0]                v_q;
  logic [KW-1:0]                kn_q;
  logic [XW-1:0]                xsq_q;
  logic [XW-1:0]                oldsq_q;
  logic [HW-1:0]                lhs_q;
  logic [KW+VL-1:0]             plo_q;
  logic [KW+VH-1:0]             phi_q;

  // output register
  logic                         out_valid_q, out_valid_d;
  wsod_pkg::status_e            out_status_q;
  logic [wsod_pkg::COUNT_W-1:0] out_number_q;

  // control
  logic                         out_free;
  logic                         load_a;
  logic                         emit;
  logic                         win_we;
  wsod_pkg::status_e            emit_status;
  logic [wsod_pkg::COUNT_W-1:0] emit_number;
  wsod_pkg::status_e            final_status;

  // combinational stage values
  logic [NW-1:0]         n;
  logic [NW-1:0]         nm1;
  logic signed [DW-1:0]  a_nx;
  logic signed [DW-1:0]  a_d;
  logic [AW-1:0]         a_dmag;
  logic [AW-1:0]         a_smag;
  logic signed [2*SB-1:0] b_xprod;
  logic signed [2*SB-1:0] c_oprod;
  logic [CW-1:0]         f_lhs;
  logic [CW-1:0]         f_rhs;
  logic                  outside;

  assign n        = cfg_i.window_size;
  assign nm1      = n - {{(NW-1){1'b0}}, 1'b1};
  assign out_free = !out_valid_q || out_o.ready;

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.sample_number = out_number_q;

  // step A: straight from the queue head
  assign a_nx   = DW'($signed(q_sample_i)) * DW'($signed({1'b0, n}));
  assign a_d    = a_nx - DW'(sum_q);
  assign a_dmag = a_d[DW-1] ? AW'(-a_d) : AW'(a_d);
  assign a_smag = sum_q[SW-1] ? AW'(-sum_q) : AW'(sum_q);

  assign b_xprod = (2 * SB)'(x_q) * (2 * SB)'(x_q);
  assign c_oprod = (2 * SB)'($signed(rd_q)) * (2 * SB)'($signed(rd_q));

  assign f_lhs   = CW'(lhs_q) << wsod_pkg::SIGMA_SHIFT;
  assign f_rhs   = (CW'(phi_q) << VL) + CW'(plo_q);
  assign outside = f_lhs > f_rhs;

  always_comb begin
    if (fill_q < n) begin
      final_status = wsod_pkg::ST_INSUFFICIENT;
    end else if (!outside) begin
      final_status = wsod_pkg::ST_NOMINAL;
    end else if (d_neg_q) begin
      final_status = wsod_pkg::ST_BELOW;
    end else begin
      final_status = wsod_pkg::ST_ABOVE;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wsod_pkg::S_IDLE: begin
        if (q_valid_i && q_job_i.sigma) begin
          state_d = wsod_pkg::S_MULB;
        end
      end
      wsod_pkg::S_MULB:  state_d = wsod_pkg::S_MULC;
      wsod_pkg::S_MULC:  state_d = wsod_pkg::S_FINAL;
      wsod_pkg::S_FINAL: begin
        if (out_free) begin
          state_d = wsod_pkg::S_IDLE;
        end
      end
      default: state_d = wsod_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop_o     = 1'b0;
    load_a      = 1'b0;
    emit        = 1'b0;
    win_we      = 1'b0;
    emit_status = final_status;
    emit_number = number_q;
    unique case (state_q)
      wsod_pkg::S_IDLE: begin
        if (q_valid_i) begin
          if (q_job_i.sigma) begin
            q_pop_o = 1'b1;
            load_a  = 1'b1;
          end else if (out_free) begin
            q_pop_o     = 1'b1;
            emit        = 1'b1;
            emit_status = q_job_i.status;
            emit_number = q_job_i.number;
          end
        end
      end
      wsod_pkg::S_FINAL: begin
        if (out_free) begin
          emit   = 1'b1;
          win_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // window update; the oldest sample leaves once the window is full
  always_comb begin
    slot_d = slot_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    sq_d   = sq_q;
    if (clear_i) begin
      slot_d = '0;
      fill_d = '0;
      sum_d  = '0;
      sq_d   = '0;
    end else if (win_we) begin
      if (fill_q >= n) begin
        sum_d = sum_q + SW'(x_q) - SW'($signed(rd_q));
        sq_d  = sq_q + QW'(xsq_q) - QW'(oldsq_q);
      end else begin
        fill_d = fill_q + 1'b1;
        sum_d  = sum_q + SW'(x_q);
        sq_d   = sq_q + QW'(xsq_q);
      end
      slot_d = ((IW'(slot_q) + 1'b1) >= IW'(n)) ? '0 : slot_q + 1'b1;
    end
  end

  assign out_valid_d = emit || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsod_pkg::S_IDLE;
      slot_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      sq_q        <= sq_d;
      out_valid_q <= out_valid_d;
    end
  end

  // window store: one write, one registered read at the slot to replace
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[slot_q] <= x_q;
    end
    rd_q <= win_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (load_a) begin
      x_q      <= $signed(q_sample_i);
      number_q <= q_job_i.number;
      d_neg_q  <= a_d[DW-1];
      dmag_q   <= a_dmag;
      nq_q     <= VW'(sq_q) * VW'(n);
      s2_q     <= (2 * AW)'(a_smag) * (2 * AW)'(a_smag);
      k2_q     <= (2 * SFW)'(cfg_i.sigma_factor) * (2 * SFW)'(cfg_i.sigma_factor);
    end
    if (state_q == wsod_pkg::S_MULB) begin
      dsq_q <= (2 * AW)'(dmag_q) * (2 * AW)'(dmag_q);
      v_q   <= (EW'(nq_q) > EW'(s2_q)) ? VW'(EW'(nq_q) - EW'(s2_q)) : '0;
      kn_q  <= KW'(k2_q) * KW'(n);
      xsq_q <= b_xprod[XW-1:0];
    end
    if (state_q == wsod_pkg::S_MULC) begin
      lhs_q   <= HW'(dsq_q) * HW'(nm1);
      plo_q   <= (KW + VL)'(kn_q) * (KW + VL)'(v_q[VL-1:0]);
      phi_q   <= (KW + VH)'(kn_q) * (KW + VH)'(v_q[VW-1:VL]);
      oldsq_q <= c_oprod[XW-1:0];
    end
    if (emit) begin
      out_status_q <= emit_status;
      out_number_q <= emit_number;
    end
  end

  `WSOD_ASSERT(a_fill_bound, fill_q <= n, "window fill above window size")
  `WSOD_IMPLIES(a_pop_idle, q_pop_o, (state_q == wsod_pkg::S_IDLE) && q_valid_i,
                "queue popped outside idle")
  `WSOD_NEXT(a_final_emits, (state_q == wsod_pkg::S_FINAL) && out_free,
             out_valid_q && (state_q == wsod_pkg::S_IDLE), "sigma result not registered")
  `WSOD_NEXT(a_out_hold, out_valid_q && !out_o.ready, out_valid_q, "result dropped while stalled")

endmodule

/* rtl/window_sigma_outlier_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_sigma_outlier_detector_unit
// Flags samples outside fixed bounds or outside k sigma of a sliding window.
// ----------------------------------------------------------------------------
// Channels: in_i takes one signed sample per word, out_o returns one word per
// sample with its status and saturating sample number, cfg_i writes one
// register (index 0 mode ... 6 sigma_factor) per word and is always ready.
// Threshold words and words with invalid settings pass the queue and the
// result register and sustain one per cycle while out_o is ready. Sigma words
// pass four steps of the back end sequencer (difference and raw products,
// squares, wide partial products, compare and window update); the back end
// takes no new word from the queue until the last step emits its result.
// A two-word queue between front and back lets samples be accepted while a
// result waits; when out_o stalls, the result register holds, the queue
// fills and in_i.ready drops.
// Reset restores the register defaults and empties the window at once; no
// clearing pass runs. Writing mode or window_size empties the window.
// ----------------------------------------------------------------------------
module window_sigma_outlier_detector_unit #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsod_in_if.sink    in_i,
  wsod_out_if.source out_o,
  wsod_cfg_if.sink   cfg_i
);

  localparam int QDW = $bits(wsod_pkg::job_t) + SAMPLE_BITS;

  wsod_pkg::cfg_t     cfg_q, cfg_d;
  wsod_pkg::reg_idx_e cfg_idx;
  logic               clear_win;

  logic                   push;
  logic                   full;
  logic                   q_valid;
  logic                   q_pop;
  wsod_pkg::job_t         front_job;
  wsod_pkg::job_t         q_job;
  logic [SAMPLE_BITS-1:0] q_sample;
  logic [QDW-1:0]         q_data;

  assign cfg_i.ready = 1'b1;
  assign cfg_idx     = wsod_pkg::reg_idx_e'(cfg_i.index);

  always_comb begin
    cfg_d     = cfg_q;
    clear_win = 1'b0;
    if (cfg_i.valid) begin
      unique case (cfg_idx)
        wsod_pkg::REG_MODE: begin
          cfg_d.mode = cfg_i.data[0];
          clear_win  = 1'b1;
        end
        wsod_pkg::REG_USE_UPPER: cfg_d.use_upper = cfg_i.data[0];
        wsod_pkg::REG_USE_LOWER: cfg_d.use_lower = cfg_i.data[0];
        wsod_pkg::REG_UPPER:     cfg_d.upper = cfg_i.data[wsod_pkg::BOUND_W-1:0];
        wsod_pkg::REG_LOWER:     cfg_d.lower = cfg_i.data[wsod_pkg::BOUND_W-1:0];
        wsod_pkg::REG_WINDOW: begin
          cfg_d.window_size = cfg_i.data[wsod_pkg::WIN_W-1:0];
          clear_win         = 1'b1;
        end
        wsod_pkg::REG_SIGMA:     cfg_d.sigma_factor = cfg_i.data[wsod_pkg::SF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= 1'b1;
      cfg_q.use_upper    <= 1'b0;
      cfg_q.use_lower    <= 1'b0;
      cfg_q.upper        <= '0;
      cfg_q.lower        <= '0;
      cfg_q.window_size  <= wsod_pkg::WIN_W'(10);
      cfg_q.sigma_factor <= wsod_pkg::SF_W'(256);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wsod_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .job_o  (front_job)
  );

  wsod_queue #(
    .W (QDW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({front_job, in_i.sample}),
    .pop_i   (q_pop),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  assign q_job    = wsod_pkg::job_t'(q_data[QDW-1:SAMPLE_BITS]);
  assign q_sample = q_data[SAMPLE_BITS-1:0];

  wsod_back #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .clear_i    (clear_win),
    .q_valid_i  (q_valid),
    .q_job_i    (q_job),
    .q_sample_i (q_sample),
    .q_pop_o    (q_pop),
    .out_o      (out_o)
  );

endmodule
